// ===== sv/cschd_pkg.sv =====
// Package for the clock sync command handler: field types, command codes,
// result kinds and status codes. No dependencies.
package cschd_pkg;

   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_CORR    = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [1:0] STATUS_RESPONSE = 2'd0;
   localparam logic [1:0] STATUS_NONE     = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;

   localparam logic [7:0] CMD_VERSION = 8'h00;
   localparam logic [7:0] CMD_APPTIME = 8'h01;
   localparam logic [7:0] CMD_PERIOD  = 8'h02;
   localparam logic [7:0] CMD_RESYNC  = 8'h03;

   localparam logic [0:0] CSR_LEAP   = 1'b0;
   localparam logic [0:0] CSR_MINCOR = 1'b1;

   localparam logic [31:0] GPS_EPOCH_SECONDS = 32'd315964800;

   // request fields, first field in the highest bits
   typedef struct packed {
      logic        answer_required;
      logic [31:0] unix_time;
      logic [7:0]  data_byte;
      logic        operation;
   } req_data_type;

   typedef struct packed {
      logic [3:0]  app_periodicity;
      logic [2:0]  resync_remaining;
      logic        resync_required;
      logic [1:0]  status;
      logic [31:0] correction;
      logic [7:0]  out_byte;
   } rsp_data_type;

endpackage

// ===== sv/clock_sync_command_handler.sv =====
// Clock sync command handler top level: control sequencer and both stores.
// Depends on cschd_pkg and cschd_mem.
//
// Payload bytes go into an inbound memory at one request per cycle while the
// block is idle and no result is waiting. A byte marked last starts a command
// walk that reads the inbound memory byte by byte (registered read data) and
// writes any answer bytes to the outbound memory; the queued answer bytes are
// then read out one at a time to the result channel.
// A time request forms the time, queues its bytes and then sends them.
// Correction items and the summary are delivered as the walk reaches them.
// rsp_tlast marks the last result of one request. The block takes one
// request at a time; csr writes are taken at any time.
module clock_sync_command_handler #(
   parameter int IN_DEPTH  = 16,
   parameter int OUT_DEPTH = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata bits: data_byte [7:0], unix_time [39:8], zero fill [47:40]
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,  // last_byte
   // tuser bits: operation [0], answer_required [1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata bits: out_byte [7:0], correction [39:8], status [41:40],
   // resync_required [42], resync_remaining [45:43], app_periodicity [49:46],
   // zero fill [55:50]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,  // end_of_run
   output logic [1:0]  rsp_tuser,  // kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import cschd_pkg::*;

   localparam int IAW = $clog2(IN_DEPTH + 1);
   localparam int OAW = $clog2(OUT_DEPTH + 1);
   localparam int IMW = $clog2(IN_DEPTH);
   localparam int OMW = $clog2(OUT_DEPTH);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;   // issue inbound read
   localparam logic [3:0] S_DEC   = 4'd2;   // inbound data valid
   localparam logic [3:0] S_APPND = 4'd3;   // write queued answer bytes
   localparam logic [3:0] S_CORR  = 4'd4;   // present correction item
   localparam logic [3:0] S_SUM   = 4'd5;   // present summary
   localparam logic [3:0] S_ORD   = 4'd6;   // issue outbound read
   localparam logic [3:0] S_OWAIT = 4'd7;   // outbound data valid
   localparam logic [3:0] S_OOUT  = 4'd8;   // present queued byte
   localparam logic [3:0] S_TREQ  = 4'd9;   // compute request time

   // walk sub-states while gathering command arguments
   localparam logic [2:0] W_CMD  = 3'd0;
   localparam logic [2:0] W_TIME = 3'd1;
   localparam logic [2:0] W_TOK  = 3'd2;
   localparam logic [2:0] W_PER  = 3'd3;
   localparam logic [2:0] W_RES  = 3'd4;

   // append sequences
   localparam logic [1:0] A_VER = 2'd0;
   localparam logic [1:0] A_PER = 2'd1;
   localparam logic [1:0] A_TRQ = 2'd2;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  walk_ff, walk_in;
   logic [1:0]  aseq_ff, aseq_in;
   logic [2:0]  apos_ff, apos_in;
   logic [7:0]  leap_ff, leap_in;
   logic [30:0] mincor_ff, mincor_in;
   logic [3:0]  token_ff, token_in;
   logic [3:0]  period_ff, period_in;
   logic [IAW-1:0] icnt_ff, icnt_in, ipos_ff, ipos_in;
   logic [OAW-1:0] ocnt_ff, ocnt_in, opos_ff, opos_in;
   logic        ovf_ff, ovf_in;
   logic        answered_ff, answered_in, rejected_ff, rejected_in;
   logic        rr_ff, rr_in, reqop_ff, reqop_in, ans_ff, ans_in;
   logic [2:0]  rem_ff, rem_in;
   logic [1:0]  argn_ff, argn_in;
   logic [31:0] corr_ff, corr_in, now_ff, now_in, treq_ff, treq_in;
   logic        vld_ff, vld_in, last_ff, last_in;
   logic [1:0]  kind_ff, kind_in;
   rsp_data_type rd_ff, rd_in;

   logic            iwe;
   logic [IMW-1:0]  iwa, ira;
   logic [7:0]      iwd, ird;
   logic            owe;
   logic [OMW-1:0]  owa, ora;
   logic [7:0]      owd, ord;

   cschd_mem #(.DEPTH(IN_DEPTH), .AW(IMW)) u_inbound (
      .clock(clock), .wr_en(iwe), .wr_addr(iwa), .wr_data(iwd),
      .rd_addr(ira), .rd_data(ird)
   );
   cschd_mem #(.DEPTH(OUT_DEPTH), .AW(OMW)) u_outbound (
      .clock(clock), .wr_en(owe), .wr_addr(owa), .wr_data(owd),
      .rd_addr(ora), .rd_data(ord)
   );

   assign req_tready = (state_ff == S_IDLE) && !vld_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {6'd0, rd_ff};

   logic [31:0] lim;
   logic [7:0]  abyte;
   logic [IAW-1:0] left;
   logic [2:0]  alen;
   logic [OAW-1:0] onext;

   always_comb begin
      state_in = state_ff; walk_in = walk_ff; aseq_in = aseq_ff; apos_in = apos_ff;
      leap_in = leap_ff; mincor_in = mincor_ff; token_in = token_ff;
      period_in = period_ff; icnt_in = icnt_ff; ipos_in = ipos_ff;
      ocnt_in = ocnt_ff; opos_in = opos_ff; ovf_in = ovf_ff;
      answered_in = answered_ff; rejected_in = rejected_ff; rr_in = rr_ff;
      reqop_in = reqop_ff; ans_in = ans_ff; rem_in = rem_ff; argn_in = argn_ff;
      corr_in = corr_ff; now_in = now_ff; treq_in = treq_ff;
      vld_in = vld_ff; last_in = last_ff; kind_in = kind_ff; rd_in = rd_ff;
      iwe = 1'b0; iwa = icnt_ff[IMW-1:0]; iwd = req_tdata[7:0];
      ira = ipos_ff[IMW-1:0];
      owe = 1'b0; owa = ocnt_ff[OMW-1:0]; owd = 8'd0;
      ora = opos_ff[OMW-1:0];
      onext = opos_ff + 1'b1;
      lim = 32'd0 - {1'b0, mincor_ff};
      left = icnt_ff - ipos_ff;
      abyte = 8'd0;
      alen = 3'd6;

      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end
      if (csr_valid) begin
         if (csr_index == CSR_LEAP) begin
            leap_in = csr_data[7:0];
         end else begin
            mincor_in = csr_data[30:0];
         end
      end

      case (aseq_ff)
         A_VER: begin
            alen = 3'd3;
            abyte = (apos_ff == 3'd0) ? 8'h00 : 8'h01;
         end
         A_PER: begin
            alen = 3'd6;
            abyte = (apos_ff == 3'd0) ? 8'h02 : (apos_ff == 3'd1) ? 8'h01 : 8'h00;
         end
         default: begin
            alen = 3'd6;
            case (apos_ff)
               3'd0: abyte = 8'h01;
               3'd1: abyte = treq_ff[7:0];
               3'd2: abyte = treq_ff[15:8];
               3'd3: abyte = treq_ff[23:16];
               3'd4: abyte = treq_ff[31:24];
               default: abyte = {3'b000, ans_ff, token_ff};
            endcase
         end
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               now_in = req_tdata[39:8];
               if (req_tuser[0]) begin
                  reqop_in = 1'b1;
                  ans_in = req_tuser[1];
                  ocnt_in = '0;
                  state_in = S_TREQ;
               end else begin
                  reqop_in = 1'b0;
                  // forced resync requests never ask for an answer
                  ans_in = 1'b0;
                  if (icnt_ff < IAW'(IN_DEPTH)) begin
                     iwe = 1'b1;
                     icnt_in = icnt_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_tlast) begin
                     ocnt_in = '0; ipos_in = '0; walk_in = W_CMD;
                     answered_in = 1'b0; rr_in = 1'b0; rem_in = '0;
                     rejected_in = ovf_ff || !(icnt_ff < IAW'(IN_DEPTH));
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_TREQ: begin
            treq_in = now_ff - GPS_EPOCH_SECONDS + {24'd0, leap_ff};
            token_in = token_ff + 4'd1;
            aseq_in = A_TRQ; apos_in = '0;
            state_in = S_APPND;
         end
         S_FETCH: begin
            if (rejected_ff || ipos_ff == icnt_ff) begin
               state_in = S_SUM;
            end else begin
               ipos_in = ipos_ff + 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_FETCH;
            case (walk_ff)
               W_CMD: begin
                  case (ird)
                     CMD_VERSION: begin
                        answered_in = 1'b1; aseq_in = A_VER; apos_in = '0;
                        state_in = S_APPND;
                     end
                     CMD_APPTIME: begin
                        if (left < IAW'(5)) begin
                           state_in = S_SUM;
                        end else begin
                           walk_in = W_TIME; argn_in = '0;
                        end
                     end
                     CMD_PERIOD: begin
                        if (left == '0) state_in = S_SUM;
                        else walk_in = W_PER;
                     end
                     CMD_RESYNC: begin
                        if (left == '0) state_in = S_SUM;
                        else walk_in = W_RES;
                     end
                     default: begin
                        rejected_in = 1'b1;
                        state_in = S_SUM;
                     end
                  endcase
               end
               W_TIME: begin
                  corr_in = {ird, corr_ff[31:8]};
                  argn_in = argn_ff + 2'd1;
                  if (argn_ff == 2'd3) walk_in = W_TOK;
               end
               W_TOK: begin
                  walk_in = W_CMD;
                  if (ird[3:0] == token_ff && corr_ff >= {1'b0, mincor_ff}
                      && corr_ff <= lim) begin
                     state_in = S_CORR;
                  end
               end
               W_PER: begin
                  walk_in = W_CMD;
                  period_in = ird[3:0];
                  answered_in = 1'b1; aseq_in = A_PER; apos_in = '0;
                  state_in = S_APPND;
               end
               default: begin
                  walk_in = W_CMD;
                  if (ird[2:0] != 3'd0) begin
                     rr_in = ird[2:0] != 3'd1;
                     rem_in = ird[2:0] - 3'd1;
                     state_in = S_TREQ;
                  end else begin
                     rr_in = 1'b0; rem_in = '0;
                  end
               end
            endcase
         end
         S_APPND: begin
            if (ocnt_ff < OAW'(OUT_DEPTH)) begin
               owe = 1'b1; owd = abyte;
               ocnt_in = ocnt_ff + 1'b1;
            end
            apos_in = apos_ff + 3'd1;
            if (apos_ff == alen - 3'd1) begin
               if (reqop_ff) begin
                  opos_in = '0; state_in = S_ORD;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_CORR: begin
            if (!vld_ff) begin
               vld_in = 1'b1; last_in = 1'b0; kind_in = KIND_CORR;
               rd_in = '0; rd_in.correction = corr_ff;
               state_in = S_FETCH;
            end
         end
         S_SUM: begin
            if (!vld_ff) begin
               vld_in = 1'b1; kind_in = KIND_SUMMARY; rd_in = '0;
               rd_in.app_periodicity = period_ff;
               icnt_in = '0; ovf_in = 1'b0;
               if (rejected_ff) begin
                  rd_in.status = STATUS_REJECTED; last_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rd_in.resync_required = rr_ff;
                  rd_in.resync_remaining = rem_ff;
                  if (answered_ff) begin
                     rd_in.status = STATUS_RESPONSE;
                     last_in = (ocnt_ff == '0);
                     opos_in = '0;
                     state_in = (ocnt_ff == '0) ? S_IDLE : S_ORD;
                  end else begin
                     rd_in.status = STATUS_NONE; last_in = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_ORD: begin
            // hold the read address until the byte is presented
            state_in = S_OWAIT;
         end
         S_OWAIT: begin
            state_in = S_OOUT;
         end
         S_OOUT: begin
            if (!vld_ff) begin
               vld_in = 1'b1; kind_in = KIND_BYTE; rd_in = '0;
               rd_in.out_byte = ord;
               opos_in = onext;
               last_in = (onext == ocnt_ff);
               state_in = (onext == ocnt_ff) ? S_IDLE : S_ORD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; walk_ff <= W_CMD;
         leap_ff <= 8'd18; mincor_ff <= 31'd1;
         token_ff <= '0; period_ff <= '0; icnt_ff <= '0; ocnt_ff <= '0;
         ovf_ff <= 1'b0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; walk_ff <= walk_in;
         leap_ff <= leap_in; mincor_ff <= mincor_in;
         token_ff <= token_in; period_ff <= period_in;
         icnt_ff <= icnt_in; ocnt_ff <= ocnt_in;
         ovf_ff <= ovf_in; vld_ff <= vld_in;
      end
      aseq_ff <= aseq_in; apos_ff <= apos_in; ipos_ff <= ipos_in;
      opos_ff <= opos_in; answered_ff <= answered_in; rejected_ff <= rejected_in;
      rr_ff <= rr_in; reqop_ff <= reqop_in; ans_ff <= ans_in; rem_ff <= rem_in;
      argn_ff <= argn_in; corr_ff <= corr_in; now_ff <= now_in;
      treq_ff <= treq_in; last_ff <= last_in; kind_ff <= kind_in; rd_ff <= rd_in;
   end
endmodule

// ===== sv/cschd_mem.sv =====
// Single-port-write, single-port-read byte memory with registered read data.
// Depends on nothing.
module cschd_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for clock_sync_command_handler: streams payload bytes and
// time requests, predicts every result, checks each whole result. Needs cschd_pkg.
module testbench;
   import cschd_pkg::*;

   localparam int IN_DEPTH  = 16;
   localparam int OUT_DEPTH = 48;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       last_byte;
      logic [31:0] unix_time;
      logic       answer_required;
   } request_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic        end_of_run;
      logic [31:0] correction;
      logic [1:0]  status;
      logic        resync_required;
      logic [2:0]  resync_remaining;
      logic [3:0]  app_periodicity;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tlast = 0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic rsp_tlast;
   logic [1:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = CSR_LEAP;
   logic [31:0] csr_data = '0;

   clock_sync_command_handler #(.IN_DEPTH(IN_DEPTH), .OUT_DEPTH(OUT_DEPTH)) uut (.*);

   // predictor state
   logic [7:0]  leap_sec;
   logic [30:0] min_corr;
   logic [3:0]  tok;
   logic [3:0]  period_code;
   logic [2:0]  resync_cnt;
   logic [7:0]  in_buf [IN_DEPTH];
   int          in_cnt;
   logic [7:0]  out_buf [OUT_DEPTH];
   int          out_cnt;
   logic        in_overflow;

   request_type pending_requests[$];
   result_type  expected_results[$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_rsp = 0;
   int  idle_cycles = 0;

   initial forever #5 clock = ~clock;

   function automatic result_type mk(logic [1:0] k, logic [7:0] b, logic [31:0] c,
                                     logic [1:0] st, logic rr, logic [2:0] rem,
                                     logic [3:0] per);
      result_type r;
      r = '{k, b, 1'b0, c, st, rr, rem, per};
      return r;
   endfunction

   function automatic result_type mk_byte(logic [7:0] b);
      return mk(KIND_BYTE, b, 32'd0, STATUS_RESPONSE, 1'b0, 3'd0, 4'd0);
   endfunction

   function automatic void queue_byte(logic [7:0] b);
      if (out_cnt < OUT_DEPTH) begin
         out_buf[out_cnt] = b;
         out_cnt++;
      end
   endfunction

   function automatic void queue_time_request(logic [31:0] now, logic ans);
      logic [31:0] t;
      t = now - GPS_EPOCH_SECONDS + {24'd0, leap_sec};
      tok = tok + 4'd1;
      queue_byte(CMD_APPTIME);
      queue_byte(t[7:0]);
      queue_byte(t[15:8]);
      queue_byte(t[23:16]);
      queue_byte(t[31:24]);
      queue_byte({3'd0, ans, tok});
   endfunction

   // work out results of one accepted request
   function automatic void predict_results(request_type rq);
      result_type res[$];
      int i, size;
      bit answered, rejected, rr;
      logic [2:0] rem;
      logic [7:0] cmd;
      logic [31:0] c, lim;
      answered = 0; rejected = 0; rr = 0; rem = 0; i = 0;
      if (rq.operation) begin
         out_cnt = 0;
         queue_time_request(rq.unix_time, rq.answer_required);
         for (int k = 0; k < out_cnt; k++)
            res.push_back(mk_byte(out_buf[k]));
      end else begin
         if (in_cnt < IN_DEPTH) begin
            in_buf[in_cnt] = rq.data_byte;
            in_cnt++;
         end else begin
            in_overflow = 1;
         end
         if (!rq.last_byte) return;
         size = in_cnt;
         out_cnt = 0;
         rejected = in_overflow;
         while (!rejected && i < size) begin
            cmd = in_buf[i];
            i++;
            if (cmd == CMD_VERSION) begin
               queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'h01);
               answered = 1;
            end else if (cmd == CMD_APPTIME) begin
               if (size - i < 5) break;
               c = {in_buf[i+3], in_buf[i+2], in_buf[i+1], in_buf[i]};
               i += 4;
               if (in_buf[i][3:0] == tok) begin
                  lim = 32'd0 - {1'b0, min_corr};
                  if (c >= {1'b0, min_corr} && c <= lim)
                     res.push_back(mk(KIND_CORR, 8'd0, c, STATUS_RESPONSE, 1'b0,
                                      3'd0, 4'd0));
               end
               i++;
            end else if (cmd == CMD_PERIOD) begin
               if (size - i < 1) break;
               period_code = in_buf[i][3:0];
               i++;
               queue_byte(CMD_PERIOD); queue_byte(8'h01);
               repeat (4) queue_byte(8'h00);
               answered = 1;
            end else if (cmd == CMD_RESYNC) begin
               if (size - i < 1) break;
               resync_cnt = in_buf[i][2:0];
               i++;
               if (resync_cnt != 0) begin
                  rr = resync_cnt != 1;
                  rem = resync_cnt - 3'd1;
                  queue_time_request(rq.unix_time, 1'b0);
               end else begin
                  rr = 0; rem = 0;
               end
            end else begin
               rejected = 1;
            end
         end
         in_cnt = 0;
         in_overflow = 0;
         if (rejected)
            res.push_back(mk(KIND_SUMMARY, 8'd0, 32'd0, STATUS_REJECTED, 1'b0, 3'd0,
                             period_code));
         else if (answered) begin
            res.push_back(mk(KIND_SUMMARY, 8'd0, 32'd0, STATUS_RESPONSE, rr, rem,
                             period_code));
            for (int k = 0; k < out_cnt; k++)
               res.push_back(mk_byte(out_buf[k]));
         end else
            res.push_back(mk(KIND_SUMMARY, 8'd0, 32'd0, STATUS_NONE, rr, rem,
                             period_code));
      end
      if (res.size() > 0) res[res.size()-1].end_of_run = 1;
      foreach (res[k]) expected_results.push_back(res[k]);
   endfunction

   // driver: offer the head of the pending queue, idle at random
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_results(pending_requests.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1;
               req_tdata  <= {8'd0, pending_requests[0].unix_time,
                              pending_requests[0].data_byte};
               req_tlast  <= pending_requests[0].last_byte;
               req_tuser  <= {pending_requests[0].answer_required,
                              pending_requests[0].operation};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // caution: the driver pops at the accepting edge, so pending[0] above is next one
   // monitor: check each accepted result against the oldest expectation
   always @(posedge clock) begin
      result_type got, exp_r;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[39:8],
                    rsp_tdata[41:40], rsp_tdata[42], rsp_tdata[45:43], rsp_tdata[49:46]};
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result %h", $time, got);
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  errors++;
                  $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
               end
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
         // watchdog: count cycles with no handshake
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   task automatic push_req(logic op, logic [7:0] b, logic last, logic [31:0] t, logic ans);
      request_type r;
      r = '{op, b, last, t, ans};
      pending_requests.push_back(r);
   endtask

   task automatic push_payload(input logic [7:0] bytes[$], input logic [31:0] t);
      foreach (bytes[k])
         push_req(1'b0, bytes[k], k == bytes.size()-1, t, 1'($urandom_range(1)));
   endtask

   // wait until the block has drained, then let it settle
   task automatic drain();
      wait (pending_requests.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx == CSR_LEAP) leap_sec = val[7:0];
      else min_corr = val[30:0];
   endtask

   // random payload: mostly well formed command lists, sometimes noise
   task automatic random_payload();
      logic [7:0] p[$];
      logic [31:0] c;
      int n;
      n = $urandom_range(1, 4);
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 20)) p.push_back(8'($urandom));
      end else begin
         repeat (n) begin
            case ($urandom_range(3))
               0: p.push_back(CMD_VERSION);
               1: begin
                  case ($urandom_range(3))
                     0: c = 32'd0;
                     1: c = {1'b0, min_corr};
                     2: c = 32'd0 - {1'b0, min_corr};
                     default: c = $urandom;
                  endcase
                  p.push_back(CMD_APPTIME);
                  p.push_back(c[7:0]); p.push_back(c[15:8]);
                  p.push_back(c[23:16]); p.push_back(c[31:24]);
                  p.push_back($urandom_range(3) != 0 ? {4'($urandom_range(15)), tok}
                                                     : 8'($urandom));
               end
               2: begin p.push_back(CMD_PERIOD); p.push_back(8'($urandom)); end
               default: begin p.push_back(CMD_RESYNC); p.push_back(8'($urandom)); end
            endcase
         end
         while (p.size() > IN_DEPTH) void'(p.pop_back());
         if ($urandom_range(7) == 0) void'(p.pop_back());
         if (p.size() == 0) p.push_back(CMD_VERSION);
      end
      push_payload(p, $urandom);
   endtask

   initial begin
      logic [7:0] p[$];
      leap_sec = 8'd18; min_corr = 31'd1; tok = 0; period_code = 0;
      resync_cnt = 0; in_cnt = 0; out_cnt = 0; in_overflow = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      write_csr(CSR_LEAP, 32'd0);
      write_csr(CSR_MINCOR, 32'd0);

      // directed: request extremes, each command, truncation, unknown, oversize
      push_req(1'b1, 8'hFF, 1'b1, 32'h0000_0000, 1'b0);
      push_req(1'b1, 8'h00, 1'b0, 32'hFFFF_FFFF, 1'b1);
      p = '{CMD_VERSION}; push_payload(p, 0);
      p = '{CMD_PERIOD, 8'hFF, CMD_VERSION}; push_payload(p, 32'hFFFF_FFFF);
      // token is 3 here after requests and this resync; zero correction passes
      p = '{CMD_RESYNC, 8'h07}; push_payload(p, 32'h1234_5678);
      p = '{CMD_APPTIME, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03}; push_payload(p, 0);
      p = '{CMD_APPTIME, 8'h00, 8'h00}; push_payload(p, 0);
      p = '{CMD_VERSION, 8'h80}; push_payload(p, 0);
      p = '{CMD_RESYNC, 8'h00}; push_payload(p, 0);
      drain();
      p = {};
      repeat (IN_DEPTH + 2) p.push_back(CMD_VERSION);
      push_payload(p, 0);
      p = {};
      repeat (IN_DEPTH) p.push_back(CMD_VERSION);
      push_payload(p, 0);   // outbound fills exactly, no bytes dropped
      drain();

      // back pressure: receiver holds off while sender keeps going
      hold_rsp = 1;
      repeat (6) push_req(1'b1, 8'd0, 1'b0, $urandom, 1'($urandom_range(1)));
      repeat (400) @(posedge clock);
      hold_rsp = 0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         case (ph)
            1: begin write_csr(CSR_LEAP, 32'hFF); write_csr(CSR_MINCOR, 32'h7FFF_FFFF); end
            2: begin write_csr(CSR_LEAP, 32'd18); write_csr(CSR_MINCOR, 32'd1); end
            3: begin
               write_csr(CSR_LEAP, $urandom);
               write_csr(CSR_MINCOR, 32'($urandom_range(1000)));
            end
            4: write_csr(CSR_MINCOR, $urandom);
            default: ;
         endcase
         repeat (4) begin
            if ($urandom_range(4) == 0)
               push_req(1'b1, 8'($urandom), 1'($urandom), $urandom, 1'($urandom));
            else random_payload();
         end
         drain();
      end

      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule

// ===== clock_sync_command_handler.f =====
sv/cschd_pkg.sv
sv/cschd_mem.sv
sv/clock_sync_command_handler.sv
bench/testbench.sv
